/* src/dle_pkg.sv */
// shared types and constants for the decimal line input editor
`default_nettype none

package dle_pkg;

  localparam int unsigned ValW         = 34;
  localparam int unsigned CntW         = 4;
  localparam int unsigned NumW         = 32;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned MaxRes       = 3;
  localparam int unsigned DefMaxDigits = 10;

  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharBs    = 8'h08;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;

  typedef enum logic [0:0] {
    KindEcho   = 1'b0,
    KindNumber = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] echo_byte;
    logic [NumW-1:0]  number;
  } result_t;

  // cnt is the number of valid results, zero when the byte gives none
  typedef struct packed {
    logic [1:0]             cnt;
    result_t [MaxRes-1:0]   res;
  } bundle_t;

endpackage

`default_nettype wire

/* src/dle_core.sv */
// entry state, digit history and result generation for one received byte
`default_nettype none

module dle_core #(
  parameter int unsigned MaxDigits = dle_pkg::DefMaxDigits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire logic [dle_pkg::ByteW-1:0]  rx_byte_i,
  output dle_pkg::bundle_t                bundle_o
);
  import dle_pkg::*;

  localparam int unsigned IdxW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  logic [ValW-1:0] val_q, val_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] hist_q [MaxDigits];

  logic            is_digit;
  logic [3:0]      digit;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] cnt_dec;
  logic            finish;
  logic [ValW-1:0] val_mul;
  logic            hist_we;

  assign is_digit = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign digit    = rx_byte_i[3:0];
  assign cnt_inc  = cnt_q + CntW'(1);
  assign cnt_dec  = cnt_q - CntW'(1);
  assign finish   = cnt_inc >= CntW'(MaxDigits);
  assign val_mul  = (val_q << 3) + (val_q << 1) + {{(ValW-4){1'b0}}, digit};

  always_comb begin
    bundle_o = '0;
    val_d    = val_q;
    cnt_d    = cnt_q;
    hist_we  = 1'b0;
    if (is_digit) begin
      bundle_o.res[0].kind      = KindEcho;
      bundle_o.res[0].echo_byte = rx_byte_i;
      if (finish) begin
        bundle_o.cnt           = 2'd2;
        bundle_o.res[1].kind   = KindNumber;
        bundle_o.res[1].number = val_mul[NumW-1:0];
        val_d                  = '0;
        cnt_d                  = '0;
      end else begin
        bundle_o.cnt = 2'd1;
        val_d        = val_mul;
        cnt_d        = cnt_inc;
        hist_we      = 1'b1;
      end
    end else if (rx_byte_i == CharCr) begin
      bundle_o.cnt           = 2'd1;
      bundle_o.res[0].kind   = KindNumber;
      bundle_o.res[0].number = val_q[NumW-1:0];
      val_d                  = '0;
      cnt_d                  = '0;
    end else if ((rx_byte_i == CharBs) && (cnt_q != '0)) begin
      bundle_o.cnt              = 2'd3;
      bundle_o.res[0].kind      = KindEcho;
      bundle_o.res[0].echo_byte = CharBs;
      bundle_o.res[1].kind      = KindEcho;
      bundle_o.res[1].echo_byte = CharSpace;
      bundle_o.res[2].kind      = KindEcho;
      bundle_o.res[2].echo_byte = CharBs;
      // value before the last digit, same as truncating division by ten
      val_d                     = hist_q[cnt_dec[IdxW-1:0]];
      cnt_d                     = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      cnt_q <= '0;
    end else if (fire_i) begin
      val_q <= val_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && hist_we) begin
      hist_q[cnt_q[IdxW-1:0]] <= val_q;
    end
  end

endmodule

`default_nettype wire

/* src/dle_out.sv */
// result register that hands out the results of one byte, one beat per cycle while out_stall_i is low
`default_nettype none

module dle_out (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire dle_pkg::bundle_t          bundle_i,
  output logic                           ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           kind_o,
  output logic [dle_pkg::ByteW-1:0]      echo_byte_o,
  output logic [dle_pkg::NumW-1:0]       number_o,
  output logic                           last_o
);
  import dle_pkg::*;

  bundle_t    bundle_q;
  logic [1:0] idx_q;
  logic       valid_q;
  result_t    cur;
  logic       is_last;
  logic       done;

  assign cur     = bundle_q.res[idx_q];
  assign is_last = (idx_q == (bundle_q.cnt - 2'd1));
  assign done    = valid_q && !out_stall_i && is_last;
  assign ready_o = !valid_q || done;

  assign out_valid_o = valid_q;
  assign kind_o      = cur.kind;
  assign echo_byte_o = cur.echo_byte;
  assign number_o    = cur.number;
  assign last_o      = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (valid_q && !out_stall_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

`default_nettype wire

/* src/decimal_line_input_editor.sv */
// top level of the decimal line input editor
// Received bytes enter an input register; digits are echoed and appended,
// a backspace with digits present echoes 0x08 0x20 0x08 and drops the last
// digit, a carriage return or the MaxDigits-th digit emits the value modulo
// 2^32 and clears the entry, and all other bytes are dropped without result.
// Each result beat carries last on the final beat caused by its byte. A byte
// that gives no result leaves the input register without waiting; a byte
// that gives results (one to three) waits there until the result register,
// which hands out one beat per cycle while out_stall_i is low, is idle or
// on its last beat. A taken byte passes the input register and then the
// result register before its first result is on the outputs.
`default_nettype none

module decimal_line_input_editor #(
  parameter int unsigned MaxDigits = dle_pkg::DefMaxDigits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [dle_pkg::ByteW-1:0] rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           kind_o,
  output logic [dle_pkg::ByteW-1:0]      echo_byte_o,
  output logic [dle_pkg::NumW-1:0]       number_o,
  output logic                           last_o
);
  import dle_pkg::*;

  logic [ByteW-1:0] byte_q;
  logic             byte_valid_q;
  bundle_t          bundle;
  logic             out_ready;
  logic             advance;
  logic             accept;

  assign advance    = byte_valid_q && ((bundle.cnt == 2'd0) || out_ready);
  assign in_stall_o = byte_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (accept) begin
      byte_valid_q <= 1'b1;
    end else if (advance) begin
      byte_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  dle_core #(
    .MaxDigits (MaxDigits)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .rx_byte_i (byte_q),
    .bundle_o  (bundle)
  );

  dle_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (bundle.cnt != 2'd0)),
    .bundle_i    (bundle),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .echo_byte_o (echo_byte_o),
    .number_o    (number_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
